// ===== rtl/core/vpdr_pkg.sv =====
package vpdr_pkg;

	// CORDIC datapath: Q1.30 vectors and 32-bit binary angles with guard bits
	localparam int CORDIC_ITER_DEF = 16;
	localparam int CW = 34;
	localparam logic signed [CW-1:0] CORDIC_K = 34'sd652032874;
	localparam logic signed [CW-1:0] QUARTER_TURN = 34'sd1073741824;
	localparam logic signed [CW-1:0] HALF_TURN = 34'sd2147483648;

	// Divider width
	localparam int DIV_W = 64;
	localparam int DIV_D_W = 32;

	// Multiplier operand widths
	localparam int MA_W = 28;
	localparam int MB_W = 34;
	localparam int MP_W = MA_W + MB_W;

	localparam logic signed [MB_W-1:0] INV_TWO_PI = 34'sd683565276;
	localparam logic [31:0] TAN_LIMIT = 32'h7FFF_FFFF;
	localparam logic [DIV_W-1:0] RAD_LIMIT = 64'd67108864;

	localparam logic [15:0] WHEELBASE_RESET = 16'd256;

	// Register indexes
	localparam logic REG_MODE = 1'b0;
	localparam logic REG_WHEELBASE = 1'b1;

	typedef struct packed {
		logic start;
		logic [15:0] angle;
	} cordic_req_t;

	typedef struct packed {
		logic start;
		logic [DIV_W-1:0] dividend;
		logic [DIV_D_W-1:0] divisor;
	} div_req_t;

	// Arctangent of 2^-i as a 32-bit binary angle
	function automatic logic [31:0] cordic_atan(input logic [4:0] idx);
		logic [31:0] v;
		case (idx)
			5'd0: v = 32'h20000000;
			5'd1: v = 32'h12E4051E;
			5'd2: v = 32'h09FB385B;
			5'd3: v = 32'h051111D4;
			5'd4: v = 32'h028B0D43;
			5'd5: v = 32'h0145D7E1;
			5'd6: v = 32'h00A2F61E;
			5'd7: v = 32'h00517C55;
			5'd8: v = 32'h0028BE53;
			5'd9: v = 32'h00145F2F;
			5'd10: v = 32'h000A2F98;
			5'd11: v = 32'h000517CC;
			5'd12: v = 32'h00028BE6;
			5'd13: v = 32'h000145F3;
			5'd14: v = 32'h0000A2FA;
			5'd15: v = 32'h0000517D;
			5'd16: v = 32'h000028BE;
			5'd17: v = 32'h0000145F;
			5'd18: v = 32'h00000A30;
			5'd19: v = 32'h00000518;
			5'd20: v = 32'h0000028C;
			5'd21: v = 32'h00000146;
			5'd22: v = 32'h000000A3;
			5'd23: v = 32'h00000051;
			default: v = 32'h0;
		endcase
		return v;
	endfunction

endpackage

// ===== rtl/core/vpdr_cordic.sv =====
module vpdr_cordic import vpdr_pkg::*; #(
	parameter int ITER = CORDIC_ITER_DEF
) (
	input logic clk,
	input logic arst_n,
	input cordic_req_t req,
	output logic done,
	output logic signed [CW-1:0] cos_val,
	output logic signed [CW-1:0] sin_val
);

	localparam int CNT_W = $clog2(ITER);

	logic busy_q;
	logic done_q;
	logic neg_q;
	logic [CNT_W-1:0] i_q;
	logic signed [CW-1:0] x_q, y_q, a_q;
	logic signed [CW-1:0] a_in, dx, dy, at;

	assign a_in = CW'($signed({req.angle, 16'h0}));
	assign dx = y_q >>> i_q;
	assign dy = x_q >>> i_q;
	assign at = $signed({2'b00, cordic_atan(5'(i_q))});

	// Load folded angle, then rotate one step per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			i_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				i_q <= '0;
			end else if (busy_q) begin
				if (i_q == CNT_W'(ITER - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				i_q <= i_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			x_q <= CORDIC_K;
			y_q <= '0;
			if (a_in > QUARTER_TURN) begin
				a_q <= a_in - HALF_TURN;
				neg_q <= 1'b1;
			end else if (a_in < -QUARTER_TURN) begin
				a_q <= a_in + HALF_TURN;
				neg_q <= 1'b1;
			end else begin
				a_q <= a_in;
				neg_q <= 1'b0;
			end
		end else if (busy_q) begin
			if (a_q >= 0) begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				a_q <= a_q - at;
			end else begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				a_q <= a_q + at;
			end
		end
	end

	assign done = done_q;
	assign cos_val = neg_q ? -x_q : x_q;
	assign sin_val = neg_q ? -y_q : y_q;

endmodule

// ===== rtl/core/vpdr_div.sv =====
module vpdr_div import vpdr_pkg::*; (
	input logic clk,
	input logic arst_n,
	input div_req_t req,
	output logic done,
	output logic [DIV_W-1:0] quotient
);

	localparam int CNT_W = $clog2(DIV_W);

	logic busy_q;
	logic done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DIV_W-1:0] n_q;
	logic [DIV_D_W-1:0] d_q;
	logic [DIV_D_W-1:0] rem_q;
	logic [DIV_D_W:0] rem_sh;
	logic take;

	assign rem_sh = {rem_q, n_q[DIV_W-1]};
	assign take = rem_sh >= {1'b0, d_q};

	// Restoring division, one quotient bit per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				if (cnt_q == CNT_W'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			n_q <= req.dividend;
			d_q <= req.divisor;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= take ? DIV_D_W'(rem_sh - {1'b0, d_q}) : DIV_D_W'(rem_sh);
			n_q <= {n_q[DIV_W-2:0], take};
		end
	end

	assign done = done_q;
	assign quotient = n_q;

endmodule

// ===== rtl/core/vehicle_pose_dead_reckoning.sv =====
// Dead-reckoning pose integrator (kinematic bicycle or particle model). Each accepted transaction
// (speed Q8.8, steer angle as a binary angle) advances the stored pose and returns
// x, y (Q16.16, saturating), heading (65536 = full turn) and a saturation flag.
// In particle mode (model_mode = 0) the steer angle is added to the heading as it is;
// in bicycle mode it passes the tangent and radius steps, some of which are skipped
// when the tangent or the radian increment clamps. These steps use the shared
// rotation CORDIC (one step per cycle) and a 64-step restoring divider used twice,
// for the tangent and for the division by the wheelbase. Input is taken only
// while the sequencer is idle; the result sits in an output register until taken.
// Registers: model_mode at byte address 0, wheelbase (unsigned Q8.8) at address 4.
module vehicle_pose_dead_reckoning import vpdr_pkg::*; #(
	parameter int CORDIC_ITERATIONS = CORDIC_ITER_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic signed [15:0] speed,
	input logic signed [15:0] steer_angle,
	output logic out_valid,
	input logic out_stall,
	output logic signed [31:0] pos_x,
	output logic signed [31:0] pos_y,
	output logic [15:0] heading,
	output logic saturated,
	input logic psel,
	input logic penable,
	input logic pwrite,
	input logic [2:0] paddr,
	input logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_TANC = 4'd1;
	localparam logic [3:0] S_TAND = 4'd2;
	localparam logic [3:0] S_MUL1 = 4'd3;
	localparam logic [3:0] S_RSTART = 4'd4;
	localparam logic [3:0] S_RDIV = 4'd5;
	localparam logic [3:0] S_MUL2 = 4'd6;
	localparam logic [3:0] S_INC = 4'd7;
	localparam logic [3:0] S_HEAD = 4'd8;
	localparam logic [3:0] S_POSC = 4'd9;
	localparam logic [3:0] S_MULX = 4'd10;
	localparam logic [3:0] S_MULY = 4'd11;
	localparam logic [3:0] S_UPDY = 4'd12;
	localparam logic [3:0] S_FIN = 4'd13;

	logic [3:0] state_q;
	logic mode_q;
	logic [15:0] wb_q;
	logic signed [31:0] x_q, y_q;
	logic [15:0] heading_q;
	logic signed [15:0] v_q;
	logic sat_q;
	logic neg_q;
	logic signed [31:0] t_q;
	logic signed [MA_W-1:0] r_q;
	logic signed [16:0] inc_q;
	logic signed [MP_W-1:0] prod_q;
	logic out_valid_q;
	logic signed [31:0] out_x_q, out_y_q;
	logic [15:0] out_h_q;
	logic out_sat_q;

	cordic_req_t cor_req;
	div_req_t div_req;
	logic cor_done, div_done;
	logic signed [CW-1:0] cor_c, cor_s;
	logic [DIV_W-1:0] div_q;

	logic in_acc, cfg_wr;
	logic [15:0] h_new;
	logic [CW-1:0] s_mag;
	logic [MP_W-1:0] p_mag;
	logic [15:0] wb_eff;
	logic signed [MA_W-1:0] mul_a;
	logic signed [MB_W-1:0] mul_b;
	logic signed [MP_W-1:0] mul_p;
	logic signed [MP_W-1:0] rnd_inc, rnd_pos;
	logic signed [21:0] inc_w;
	logic signed [39:0] step_d;
	logic signed [40:0] pos_sum;
	logic signed [40:0] pos_base;

	assign in_acc = in_valid && !in_stall;
	assign in_stall = state_q != S_IDLE;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign pready = 1'b1;
	assign prdata = paddr[2] ? {16'h0, wb_q} : {31'h0, mode_q};

	assign h_new = heading_q + inc_q[15:0];
	assign s_mag = cor_s < 0 ? CW'(-cor_s) : CW'(cor_s);
	assign p_mag = prod_q < 0 ? MP_W'(-prod_q) : MP_W'(prod_q);
	assign wb_eff = (wb_q == 16'h0) ? 16'd1 : wb_q;

	// Request the shared CORDIC and divider
	always_comb begin
		cor_req.start = 1'b0;
		cor_req.angle = h_new;
		div_req.start = 1'b0;
		div_req.dividend = DIV_W'(s_mag) << 16;
		div_req.divisor = DIV_D_W'(cor_c);
		case (state_q)
			S_IDLE: begin
				cor_req.angle = steer_angle;
				cor_req.start = in_acc && mode_q;
			end
			S_TANC: begin
				div_req.start = cor_done && (cor_c > 0);
			end
			S_RSTART: begin
				div_req.start = 1'b1;
				div_req.dividend = DIV_W'(p_mag) << 8;
				div_req.divisor = DIV_D_W'(wb_eff);
			end
			S_HEAD: begin
				cor_req.start = 1'b1;
			end
			default: begin
			end
		endcase
	end

	// Share one multiplier across the steps
	always_comb begin
		case (state_q)
			S_MUL1: begin
				mul_a = MA_W'(v_q);
				mul_b = MB_W'(t_q);
			end
			S_MUL2: begin
				mul_a = r_q;
				mul_b = INV_TWO_PI;
			end
			S_MULY: begin
				mul_a = MA_W'(v_q);
				mul_b = cor_s;
			end
			default: begin
				mul_a = MA_W'(v_q);
				mul_b = cor_c;
			end
		endcase
	end

	assign mul_p = mul_a * mul_b;
	assign rnd_inc = prod_q + MP_W'(64'sd549755813888);
	assign inc_w = $signed(rnd_inc[MP_W-1:40]);
	assign rnd_pos = prod_q + MP_W'(64'sd2097152);
	assign step_d = $signed(rnd_pos[MP_W-1:22]);
	assign pos_base = (state_q == S_MULY) ? 41'(x_q) : 41'(y_q);
	assign pos_sum = pos_base + 41'(step_d);

	// Sequencer and configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			mode_q <= 1'b0;
			wb_q <= WHEELBASE_RESET;
			x_q <= '0;
			y_q <= '0;
			heading_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wr) begin
				case (paddr[2])
					REG_MODE: mode_q <= pwdata[0];
					REG_WHEELBASE: wb_q <= pwdata[15:0];
					default: begin
					end
				endcase
			end
			// Raise the result when the finish step loads it, drop it once taken
			if (state_q == S_FIN && (!out_valid_q || !out_stall))
				out_valid_q <= 1'b1;
			else if (out_valid_q && !out_stall)
				out_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (in_acc)
						state_q <= mode_q ? S_TANC : S_HEAD;
				end
				S_TANC: begin
					if (cor_done)
						state_q <= (cor_c > 0) ? S_TAND : S_MUL1;
				end
				S_TAND: begin
					if (div_done)
						state_q <= S_MUL1;
				end
				S_MUL1: state_q <= S_RSTART;
				S_RSTART: state_q <= S_RDIV;
				S_RDIV: begin
					if (div_done)
						state_q <= (div_q > RAD_LIMIT) ? S_HEAD : S_MUL2;
				end
				S_MUL2: state_q <= S_INC;
				S_INC: state_q <= S_HEAD;
				S_HEAD: begin
					heading_q <= h_new;
					state_q <= S_POSC;
				end
				S_POSC: begin
					if (cor_done)
						state_q <= S_MULX;
				end
				S_MULX: state_q <= S_MULY;
				S_MULY: begin
					if (pos_sum > 41'sd2147483647)
						x_q <= 32'sh7FFF_FFFF;
					else if (pos_sum < -41'sd2147483648)
						x_q <= 32'sh8000_0000;
					else
						x_q <= 32'(pos_sum);
					state_q <= S_UPDY;
				end
				S_UPDY: begin
					if (pos_sum > 41'sd2147483647)
						y_q <= 32'sh7FFF_FFFF;
					else if (pos_sum < -41'sd2147483648)
						y_q <= 32'sh8000_0000;
					else
						y_q <= 32'(pos_sum);
					state_q <= S_FIN;
				end
				S_FIN: begin
					if (!out_valid_q || !out_stall)
						state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (in_acc) begin
					v_q <= speed;
					inc_q <= 17'(steer_angle);
					sat_q <= 1'b0;
				end
			end
			S_TANC: begin
				if (cor_done) begin
					neg_q <= cor_s < 0;
					if (cor_c <= 0) begin
						t_q <= (cor_s >= 0) ? $signed(TAN_LIMIT) : -$signed(TAN_LIMIT);
						sat_q <= 1'b1;
					end
				end
			end
			S_TAND: begin
				if (div_done) begin
					if (div_q > DIV_W'(TAN_LIMIT)) begin
						t_q <= neg_q ? -$signed(TAN_LIMIT) : $signed(TAN_LIMIT);
						sat_q <= 1'b1;
					end else begin
						t_q <= neg_q ? -$signed(div_q[31:0]) : $signed(div_q[31:0]);
					end
				end
			end
			S_MUL1: prod_q <= mul_p;
			S_RSTART: neg_q <= prod_q < 0;
			S_RDIV: begin
				if (div_done) begin
					if (div_q > RAD_LIMIT) begin
						inc_q <= neg_q ? -17'sd32768 : 17'sd32768;
						sat_q <= 1'b1;
					end else begin
						r_q <= neg_q ? -$signed(div_q[MA_W-1:0]) : $signed(div_q[MA_W-1:0]);
					end
				end
			end
			S_MUL2: prod_q <= mul_p;
			S_INC: begin
				if (inc_w > 22'sd32768) begin
					inc_q <= 17'sd32768;
					sat_q <= 1'b1;
				end else if (inc_w < -22'sd32768) begin
					inc_q <= -17'sd32768;
					sat_q <= 1'b1;
				end else begin
					inc_q <= 17'(inc_w);
				end
			end
			S_MULX: prod_q <= mul_p;
			S_MULY: begin
				prod_q <= mul_p;
				if (pos_sum > 41'sd2147483647 || pos_sum < -41'sd2147483648)
					sat_q <= 1'b1;
			end
			S_UPDY: begin
				if (pos_sum > 41'sd2147483647 || pos_sum < -41'sd2147483648)
					sat_q <= 1'b1;
			end
			S_FIN: begin
				if (!out_valid_q || !out_stall) begin
					out_x_q <= x_q;
					out_y_q <= y_q;
					out_h_q <= heading_q;
					out_sat_q <= sat_q;
				end
			end
			default: begin
			end
		endcase
	end

	vpdr_cordic #(
		.ITER(CORDIC_ITERATIONS)
	) u_cordic (
		.clk(clk),
		.arst_n(arst_n),
		.req(cor_req),
		.done(cor_done),
		.cos_val(cor_c),
		.sin_val(cor_s)
	);

	vpdr_div u_div (
		.clk(clk),
		.arst_n(arst_n),
		.req(div_req),
		.done(div_done),
		.quotient(div_q)
	);

	assign out_valid = out_valid_q;
	assign pos_x = out_x_q;
	assign pos_y = out_y_q;
	assign heading = out_h_q;
	assign saturated = out_sat_q;

	// A result appears only when the sequencer finishes an item
	a_out_from_fin: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == S_FIN)
		else $error("result raised outside finish step");

	// Heading moves only in the heading step
	a_heading_step: assert property (@(posedge clk) disable iff (!arst_n)
		heading_q != $past(heading_q) |-> $past(state_q) == S_HEAD)
		else $error("heading changed outside heading step");

	// Finish waits while the output slot is still occupied
	a_fin_hold: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_FIN && out_valid_q && out_stall |=> state_q == S_FIN)
		else $error("finish overran pending result");

	// Divider and CORDIC never finish while idle
	a_idle_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == S_IDLE |-> !cor_done && !div_done)
		else $error("arithmetic unit finished while idle");

endmodule

// ===== tb/vehicle_pose_dead_reckoning_tb.sv =====
`timescale 1ns / 100ps
module vehicle_pose_dead_reckoning_tb;
	import vpdr_pkg::*;

	localparam int N_ITER = 16;
	localparam int STALL_LIMIT = 20000;
	localparam logic [2:0] ADDR_MODE = 3'd0;
	localparam logic [2:0] ADDR_WHEELBASE = 3'd4;
	localparam logic MODE_PARTICLE = 1'b0;
	localparam logic MODE_BICYCLE = 1'b1;

	typedef struct packed {
		logic signed [31:0] x;
		logic signed [31:0] y;
		logic [15:0] hdg;
		logic sat;
	} pose_t;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic signed [15:0] speed;
	logic signed [15:0] steer_angle;
	logic out_valid;
	logic out_stall;
	logic signed [31:0] pos_x;
	logic signed [31:0] pos_y;
	logic [15:0] heading;
	logic saturated;
	logic psel;
	logic penable;
	logic pwrite;
	logic [2:0] paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic pready;

	// predictor state
	logic mdl_mode;
	logic [15:0] mdl_wheelbase;
	logic signed [31:0] mdl_x;
	logic signed [31:0] mdl_y;
	logic [15:0] mdl_hdg;

	pose_t expected_poses[$];
	int errors = 0;
	int idle_cycles = 0;
	bit hold_req;
	bit hold_done = 0;
	bit rx_random;

	vehicle_pose_dead_reckoning dut (.*);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// floor shift of a signed value
	function automatic longint shr_floor(input longint v, input int s);
		return v >>> s;
	endfunction

	function automatic longint atan_step(input int i);
		logic [31:0] t[24] = '{32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
			32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53,
			32'h00145F2F, 32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3,
			32'h0000A2FA, 32'h0000517D, 32'h000028BE, 32'h0000145F, 32'h00000A30,
			32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};
		return longint'(t[i]);
	endfunction

	// rotation CORDIC on a 16-bit binary angle, Q1.30 outputs
	task automatic sin_cos(input logic [15:0] ang, output longint c, output longint s);
		longint a;
		longint vx;
		longint vy;
		longint dx;
		longint dy;
		bit flip;
		a = longint'($signed({ang, 16'h0}));
		flip = 0;
		vx = 652032874;
		vy = 0;
		if (a > 64'sd1073741824) begin
			a -= 64'sd2147483648;
			flip = 1;
		end else if (a < -64'sd1073741824) begin
			a += 64'sd2147483648;
			flip = 1;
		end
		for (int i = 0; i < N_ITER; i++) begin
			dx = shr_floor(vy, i);
			dy = shr_floor(vx, i);
			if (a >= 0) begin
				vx -= dx;
				vy += dy;
				a -= atan_step(i);
			end else begin
				vx += dx;
				vy -= dy;
				a += atan_step(i);
			end
		end
		c = flip ? -vx : vx;
		s = flip ? -vy : vy;
	endtask

	function automatic logic signed [31:0] clamp_pos(input longint v, inout bit sat);
		if (v > 64'sd2147483647) begin
			sat = 1;
			return 32'sh7FFFFFFF;
		end
		if (v < -64'sd2147483648) begin
			sat = 1;
			return 32'sh80000000;
		end
		return v[31:0];
	endfunction

	// advance the predicted pose by one step
	task automatic advance_pose(input logic signed [15:0] spd, input logic signed [15:0] st);
		longint v;
		longint inc;
		longint c;
		longint s;
		longint t;
		longint r;
		longint wb;
		bit sat;
		pose_t p;
		v = spd;
		sat = 0;
		if (mdl_mode == MODE_PARTICLE) begin
			inc = st;
		end else begin
			wb = (mdl_wheelbase == 0) ? 1 : longint'(mdl_wheelbase);
			sin_cos(st, c, s);
			if (c <= 0) begin
				t = (s >= 0) ? 64'sd2147483647 : -64'sd2147483647;
				sat = 1;
			end else begin
				t = (s * 65536) / c;
				if (t > 64'sd2147483647) begin
					t = 64'sd2147483647;
					sat = 1;
				end else if (t < -64'sd2147483647) begin
					t = -64'sd2147483647;
					sat = 1;
				end
			end
			r = (v * t * 256) / wb;
			if (r > (64'sd4 <<< 24)) begin
				inc = 32768;
				sat = 1;
			end else if (r < -(64'sd4 <<< 24)) begin
				inc = -32768;
				sat = 1;
			end else begin
				inc = shr_floor(r * 683565276 + (64'sd1 <<< 39), 40);
				if (inc > 32768) begin
					inc = 32768;
					sat = 1;
				end else if (inc < -32768) begin
					inc = -32768;
					sat = 1;
				end
			end
		end
		mdl_hdg = mdl_hdg + inc[15:0];
		sin_cos(mdl_hdg, c, s);
		mdl_x = clamp_pos(longint'(mdl_x) + shr_floor(v * c + (64'sd1 <<< 21), 22), sat);
		mdl_y = clamp_pos(longint'(mdl_y) + shr_floor(v * s + (64'sd1 <<< 21), 22), sat);
		p.x = mdl_x;
		p.y = mdl_y;
		p.hdg = mdl_hdg;
		p.sat = sat;
		expected_poses.push_back(p);
	endtask

	// offer one transaction, hold until accepted, then idle a random gap
	task automatic send_step(input logic signed [15:0] spd, input logic signed [15:0] st);
		int gap;
		in_valid <= 1'b1;
		speed <= spd;
		steer_angle <= st;
		do @(posedge clk); while (in_stall);
		advance_pose(spd, st);
		gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60) :
			($urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 3));
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
		in_valid <= 1'b0;
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= data;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		if (addr == ADDR_MODE) mdl_mode = data[0];
		else mdl_wheelbase = data[15:0];
	endtask

	// wait for all results, then let the sequencer settle before touching registers
	task automatic drain;
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_poses.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
	endtask

	task automatic set_mode(input logic m, input logic [15:0] wb);
		drain();
		reg_write(ADDR_MODE, {31'h0, m});
		reg_write(ADDR_WHEELBASE, {16'h0, wb});
	endtask

	task automatic test_particle_directed;
		set_mode(MODE_PARTICLE, 16'd256);
		send_step(16'sd256, 16'sd0);
		send_step(16'sh7FFF, 16'sh4000);
		send_step(16'sh8000, 16'sh8000);
		send_step(16'sh7FFF, 16'sh7FFF);
		send_step(16'sd0, -16'sd1);
		send_step(-16'sd1, 16'sh2000);
		send_step(16'sh5555, 16'shAAAA);
		send_step(16'shAAAA, 16'sh5555);
	endtask

	task automatic test_bicycle_directed;
		set_mode(MODE_BICYCLE, 16'd256);
		send_step(16'sd256, 16'sd0);
		send_step(16'sd256, 16'sh0800);
		send_step(16'sd256, 16'sh4000);
		send_step(-16'sd256, 16'shC000);
		send_step(16'sh7FFF, 16'sh3FFF);
		send_step(16'sd10, 16'sh8000);
		send_step(16'sd100, 16'sh7FFF);
		send_step(16'sh8000, 16'sh0100);
		set_mode(MODE_BICYCLE, 16'hFFFF);
		send_step(16'sh7FFF, 16'sh1000);
		send_step(16'sd1, -16'sh1000);
		set_mode(MODE_BICYCLE, 16'd1);
		send_step(16'sd1, 16'sd1);
		send_step(16'sh7FFF, 16'sh0010);
		set_mode(MODE_BICYCLE, 16'd0);
		send_step(16'sd3, 16'sd7);
	endtask

	// align the heading with x, then run straight at full speed into the clamp
	task automatic test_position_saturation;
		set_mode(MODE_PARTICLE, 16'd256);
		send_step(16'sd0, 16'h0 - mdl_hdg);
		for (int i = 0; i < 300; i++) send_step(16'sh7FFF, 16'sd0);
		send_step(16'sd0, 16'sh8000);
		for (int i = 0; i < 4; i++) send_step(16'sh8000, 16'sd0);
	endtask

	// receiver holds off long while the sender keeps offering
	task automatic test_backpressure;
		hold_req = 1;
		for (int i = 0; i < 6; i++) send_step(16'($urandom), 16'($urandom));
	endtask

	task automatic test_random;
		logic [15:0] wb;
		for (int ph = 0; ph < 8; ph++) begin
			wb = (ph % 3 == 0) ? 16'($urandom_range(1, 65535)) : 16'($urandom_range(64, 1024));
			set_mode(ph[0], wb);
			for (int i = 0; i < 22; i++) begin
				case ($urandom_range(0, 3))
				0: send_step(16'($urandom), 16'($urandom));
				1: send_step(16'($signed(12'($urandom))), 16'($signed(12'($urandom))));
				2: send_step(16'($urandom_range(0, 1) ? 16'h7FFF : 16'h8000), 16'($urandom));
				default: send_step(16'($urandom), 16'($signed(8'($urandom))));
				endcase
			end
		end
	endtask

	// receiver stall pattern
	initial begin
		out_stall <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (hold_req && !hold_done) begin
				out_stall <= 1'b1;
				repeat (1500) @(posedge clk);
				out_stall <= 1'b0;
				hold_done = 1;
			end else if (rx_random && $urandom_range(0, 3) == 0) begin
				out_stall <= 1'b1;
				repeat (($urandom_range(0, 15) == 0) ? $urandom_range(10, 80)
					: $urandom_range(1, 3)) @(posedge clk);
				out_stall <= 1'b0;
			end
		end
	end

	// compare each result against the oldest prediction
	always @(posedge clk) begin
		pose_t e;
		if (out_valid && !out_stall) begin
			if (expected_poses.size() == 0) begin
				$display("%0t: unexpected result x=%h y=%h h=%h s=%b", $time,
					pos_x, pos_y, heading, saturated);
				errors++;
			end else begin
				e = expected_poses.pop_front();
				if (pos_x !== e.x) begin
					$display("%0t: pos_x expected %h actual %h", $time, e.x, pos_x);
					errors++;
				end
				if (pos_y !== e.y) begin
					$display("%0t: pos_y expected %h actual %h", $time, e.y, pos_y);
					errors++;
				end
				if (heading !== e.hdg) begin
					$display("%0t: heading expected %h actual %h", $time, e.hdg, heading);
					errors++;
				end
				if (saturated !== e.sat) begin
					$display("%0t: saturated expected %b actual %b", $time, e.sat,
						saturated);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no transaction
	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel)
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= STALL_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end
	end

	initial begin
		hold_req = 0;
		rx_random = 0;
		mdl_mode = MODE_PARTICLE;
		mdl_wheelbase = WHEELBASE_RESET;
		mdl_x = 0;
		mdl_y = 0;
		mdl_hdg = 0;
		arst_n = 1'b0;
		in_valid <= 1'b0;
		speed <= '0;
		steer_angle <= '0;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		paddr <= '0;
		pwdata <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_particle_directed();
		test_bicycle_directed();
		rx_random = 1;
		test_position_saturation();
		test_backpressure();
		test_random();
		drain();
		if (errors == 0 && expected_poses.size() == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule
